// ----- rtl/i2cra_pkg.sv -----
// Shared types and constants of the I2C register access master.
package i2cra_pkg;

  localparam int MAX_BYTES_DEF = 16;
  localparam logic [7:0] PHASE_TICKS_RST = 8'd5;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       sda_in;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic [4:0] byte_count;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       rd_valid;
    logic [7:0] rd_data;
    logic       rd_last;
    logic       done_res;
    logic       status;
  } out_t;

endpackage

// ----- rtl/i2cra_core.sv -----
// Bus sequencer, write buffer and per-tick result logic of the I2C master.
module i2cra_core #(
  parameter int MAX_BYTES = i2cra_pkg::MAX_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  i2cra_pkg::in_t   item,
  input  logic [7:0]       phase_ticks,
  output i2cra_pkg::out_t  result
);
  import i2cra_pkg::*;

  localparam int CntW = $clog2(MAX_BYTES + 1);
  localparam int IdxW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_START_A, S_START_B, S_START_C, S_TX_LOW, S_TX_HIGH, S_ACK_LOW,
    S_ACK_HIGH, S_RX_LOW, S_RX_HIGH, S_MACK_LOW, S_MACK_HIGH, S_STOP_A,
    S_STOP_B, S_STOP_C, S_GAP
  } bus_state_t;

  typedef enum logic [2:0] {
    G_DEV, G_REG, G_DATA, G_DEV_R, G_RDATA
  } stage_t;

  bus_state_t      bus_state_r, bus_state_nxt;
  stage_t          stage_r, stage_nxt;
  logic [7:0]      phase_count_r, phase_count_nxt;
  logic [2:0]      bit_index_r, bit_index_nxt;
  logic [7:0]      shift_byte_r, shift_byte_nxt;
  logic [CntW-1:0] bytes_left_r, bytes_left_nxt;
  logic [CntW-1:0] write_fill_r, write_fill_nxt;
  logic [7:0]      saved_device_r, saved_device_nxt;
  logic [7:0]      saved_reg_r, saved_reg_nxt;
  logic            is_read_r, is_read_nxt;
  logic            restart_r, restart_nxt;
  logic            failed_r, failed_nxt;
  logic [IdxW-1:0] rd_idx_r, rd_idx_nxt;

  logic [7:0]      buf_mem [MAX_BYTES];
  logic [7:0]      buf_q_r;
  logic            buf_we;

  logic [7:0]      eff_ticks;
  logic            phase_end;
  logic [4:0]      cnt_req;
  logic [CntW-1:0] cnt_clamped;
  logic [CntW-1:0] left_dec;
  out_t            res;

  always_comb begin
    eff_ticks   = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
    phase_end   = ({1'b0, phase_count_r} + 9'd1) >= {1'b0, eff_ticks};
    cnt_req     = (item.byte_count == 5'd0) ? 5'd1 : item.byte_count;
    cnt_clamped = (32'(cnt_req) > MAX_BYTES) ? MaxCnt : CntW'(cnt_req);
    left_dec    = (bytes_left_r != '0) ? bytes_left_r - CntW'(1) : bytes_left_r;
  end

  always_comb begin
    bus_state_nxt    = bus_state_r;
    stage_nxt        = stage_r;
    phase_count_nxt  = phase_count_r;
    bit_index_nxt    = bit_index_r;
    shift_byte_nxt   = shift_byte_r;
    bytes_left_nxt   = bytes_left_r;
    write_fill_nxt   = write_fill_r;
    saved_device_nxt = saved_device_r;
    saved_reg_nxt    = saved_reg_r;
    is_read_nxt      = is_read_r;
    restart_nxt      = restart_r;
    failed_nxt       = failed_r;
    rd_idx_nxt       = rd_idx_r;
    buf_we           = 1'b0;
    res              = '0;
    res.scl_level    = 1'b1;

    if (step) begin
      if (bus_state_r == S_IDLE) begin
        case (item.op)
          OP_PUSH: begin
            if (write_fill_r < MaxCnt) begin
              buf_we         = 1'b1;
              write_fill_nxt = write_fill_r + CntW'(1);
            end
          end
          OP_WRITE, OP_READ: begin
            saved_device_nxt = item.dev_addr;
            saved_reg_nxt    = item.reg_addr;
            is_read_nxt      = (item.op == OP_READ);
            if (item.op == OP_READ) begin
              bytes_left_nxt = cnt_clamped;
            end
            failed_nxt      = 1'b0;
            restart_nxt     = 1'b0;
            stage_nxt       = G_DEV;
            shift_byte_nxt  = item.dev_addr;
            bit_index_nxt   = 3'd0;
            phase_count_nxt = 8'd0;
            rd_idx_nxt      = '0;
            bus_state_nxt   = S_START_A;
          end
          default: begin
          end
        endcase
      end else begin
        case (bus_state_r)
          S_START_B: res.sda_pull_low = 1'b1;
          S_START_C: begin
            res.scl_level    = 1'b0;
            res.sda_pull_low = 1'b1;
          end
          S_TX_LOW: begin
            res.scl_level    = 1'b0;
            res.sda_pull_low = ~shift_byte_r[7];
          end
          S_TX_HIGH: res.sda_pull_low = ~shift_byte_r[7];
          S_ACK_LOW, S_RX_LOW: res.scl_level = 1'b0;
          S_MACK_LOW: begin
            res.scl_level    = 1'b0;
            res.sda_pull_low = (bytes_left_r > CntW'(1));
          end
          S_MACK_HIGH: res.sda_pull_low = (bytes_left_r > CntW'(1));
          S_STOP_A: begin
            res.scl_level    = 1'b0;
            res.sda_pull_low = 1'b1;
          end
          S_STOP_B: res.sda_pull_low = 1'b1;
          default: begin
          end
        endcase

        if (!phase_end) begin
          phase_count_nxt = phase_count_r + 8'd1;
        end else begin
          phase_count_nxt = 8'd0;
          case (bus_state_r)
            S_START_A: bus_state_nxt = S_START_B;
            S_START_B: bus_state_nxt = S_START_C;
            S_START_C: begin
              bit_index_nxt = 3'd0;
              bus_state_nxt = S_TX_LOW;
            end
            S_TX_LOW: bus_state_nxt = S_TX_HIGH;
            S_TX_HIGH: begin
              shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
              if (bit_index_r == 3'd7) begin
                bit_index_nxt = 3'd0;
                bus_state_nxt = S_ACK_LOW;
              end else begin
                bit_index_nxt = bit_index_r + 3'd1;
                bus_state_nxt = S_TX_LOW;
              end
            end
            S_ACK_LOW: bus_state_nxt = S_ACK_HIGH;
            S_ACK_HIGH: begin
              if (item.sda_in) begin
                failed_nxt    = 1'b1;
                bus_state_nxt = S_STOP_A;
              end else begin
                case (stage_r)
                  G_DEV: begin
                    stage_nxt      = G_REG;
                    shift_byte_nxt = saved_reg_r;
                    bus_state_nxt  = S_TX_LOW;
                  end
                  G_REG: begin
                    if (is_read_r) begin
                      restart_nxt   = 1'b1;
                      bus_state_nxt = S_STOP_A;
                    end else if (write_fill_r != '0) begin
                      bytes_left_nxt = write_fill_r;
                      stage_nxt      = G_DATA;
                      shift_byte_nxt = buf_q_r;
                      rd_idx_nxt     = rd_idx_r + IdxW'(1);
                      bus_state_nxt  = S_TX_LOW;
                    end else begin
                      bus_state_nxt = S_STOP_A;
                    end
                  end
                  G_DATA: begin
                    bytes_left_nxt = left_dec;
                    if (left_dec != '0) begin
                      shift_byte_nxt = buf_q_r;
                      rd_idx_nxt     = rd_idx_r + IdxW'(1);
                      bus_state_nxt  = S_TX_LOW;
                    end else begin
                      bus_state_nxt = S_STOP_A;
                    end
                  end
                  default: begin
                    stage_nxt      = G_RDATA;
                    shift_byte_nxt = 8'd0;
                    bit_index_nxt  = 3'd0;
                    bus_state_nxt  = S_RX_LOW;
                  end
                endcase
              end
            end
            S_RX_LOW: bus_state_nxt = S_RX_HIGH;
            S_RX_HIGH: begin
              shift_byte_nxt = {shift_byte_r[6:0], item.sda_in};
              if (bit_index_r == 3'd7) begin
                bit_index_nxt = 3'd0;
                res.rd_valid  = 1'b1;
                res.rd_data   = {shift_byte_r[6:0], item.sda_in};
                res.rd_last   = (bytes_left_r <= CntW'(1));
                bus_state_nxt = S_MACK_LOW;
              end else begin
                bit_index_nxt = bit_index_r + 3'd1;
                bus_state_nxt = S_RX_LOW;
              end
            end
            S_MACK_LOW: bus_state_nxt = S_MACK_HIGH;
            S_MACK_HIGH: begin
              bytes_left_nxt = left_dec;
              if (left_dec != '0) begin
                shift_byte_nxt = 8'd0;
                bus_state_nxt  = S_RX_LOW;
              end else begin
                bus_state_nxt = S_STOP_A;
              end
            end
            S_STOP_A: bus_state_nxt = S_STOP_B;
            S_STOP_B: bus_state_nxt = S_STOP_C;
            S_STOP_C: begin
              if (restart_r && !failed_r) begin
                restart_nxt    = 1'b0;
                stage_nxt      = G_DEV_R;
                shift_byte_nxt = saved_device_r + 8'd1;
                bus_state_nxt  = S_GAP;
              end else begin
                res.done_res = 1'b1;
                res.status   = failed_r;
                if (!is_read_r) begin
                  write_fill_nxt = '0;
                end
                bus_state_nxt = S_IDLE;
              end
            end
            S_GAP: bus_state_nxt = S_START_A;
            default: bus_state_nxt = S_IDLE;
          endcase
        end
      end
      res.busy_res = (bus_state_nxt != S_IDLE);
    end
  end

  assign result = res;

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[write_fill_r[IdxW-1:0]] <= item.wr_data;
    end
    buf_q_r <= buf_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_state_r    <= S_IDLE;
      stage_r        <= G_DEV;
      phase_count_r  <= 8'd0;
      bit_index_r    <= 3'd0;
      shift_byte_r   <= 8'd0;
      bytes_left_r   <= '0;
      write_fill_r   <= '0;
      saved_device_r <= 8'd0;
      saved_reg_r    <= 8'd0;
      is_read_r      <= 1'b0;
      restart_r      <= 1'b0;
      failed_r       <= 1'b0;
      rd_idx_r       <= '0;
    end else begin
      bus_state_r    <= bus_state_nxt;
      stage_r        <= stage_nxt;
      phase_count_r  <= phase_count_nxt;
      bit_index_r    <= bit_index_nxt;
      shift_byte_r   <= shift_byte_nxt;
      bytes_left_r   <= bytes_left_nxt;
      write_fill_r   <= write_fill_nxt;
      saved_device_r <= saved_device_nxt;
      saved_reg_r    <= saved_reg_nxt;
      is_read_r      <= is_read_nxt;
      restart_r      <= restart_nxt;
      failed_r       <= failed_nxt;
      rd_idx_r       <= rd_idx_nxt;
    end
  end

endmodule

// ----- rtl/i2c_register_access_master.sv -----
// Top level of the tick-driven I2C register access master.
// The result of an accepted tick is registered in the output register and shown in the cycle after it.
// Throughput: one tick per cycle; a tick is taken whenever the output register is
// empty or is being drained in the same cycle.
// Reset: synchronous, active low; clears the bus sequencer, the fill count and the
// output valid, and sets the phase length to 5 ticks. Buffer contents are not cleared.
module i2c_register_access_master #(
  parameter int MAX_BYTES = i2cra_pkg::MAX_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  i2cra_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output i2cra_pkg::out_t  out_data,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);
  import i2cra_pkg::*;

  logic       accept;
  logic       out_valid_r;
  out_t       out_data_r;
  out_t       result;
  logic [7:0] phase_ticks_r;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  i2cra_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .item        (in_data),
    .phase_ticks (phase_ticks_r),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      phase_ticks_r <= PHASE_TICKS_RST;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        phase_ticks_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/i2cra_checker.sv -----
// Port-level checker of the I2C register access master and its bind.
module i2cra_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input i2cra_pkg::out_t out_data
);
  import i2cra_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction gave no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with a free output register");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rd_valid |-> out_data.busy_res && !out_data.done_res)
    else $error("read byte delivered outside a running transfer");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("transfer done while still busy");

endmodule

bind i2c_register_access_master i2cra_checker u_i2cra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
